### rtl/ggnt_pkg.sv
// ----------------------------------------------------------------------------
// ggnt_pkg
// Shared types and constants for the greedy geographic neighbor table.
// ----------------------------------------------------------------------------
package ggnt_pkg;

  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned CoordBitsDef    = 20;
  localparam logic [15:0] LifetimeReset   = 16'd1000;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_DEL   = 3'd1,
    MODE_CLEAR = 3'd2,
    MODE_BEST  = 3'd3,
    MODE_QUERY = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NOBEST = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DIST,
    FSM_FINISH,
    FSM_WRITE,
    FSM_OUT
  } fsm_e;

endpackage

### rtl/ggnt_mem.sv
// ----------------------------------------------------------------------------
// ggnt_mem
// Entry store: address, position and stamp, one read and one write port.
// ----------------------------------------------------------------------------
module ggnt_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 104
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### rtl/greedy_geo_neighbor_table.sv
// ----------------------------------------------------------------------------
// greedy_geo_neighbor_table
// Neighbor position table with greedy next-hop selection.
// ----------------------------------------------------------------------------
// Input word: mode, node_addr, positions, now_ms on in_valid_i/in_stall_o.
// Result word: status, next_hop, is_present, entry_time on out_valid_o /
// out_stall_i; one result per input word.
// Entries live in one synchronous RAM (one read, one write port, registered
// read data); valid bits are flip-flops cleared at reset.
// Every add, delete, query and best-neighbor command walks all entries
// through the RAM read port: one entry is issued per cycle, except that a
// live, unexpired best-neighbor entry holds the issue while DIST squares it.
// One word at a time. A stalled result holds in the output register; no new
// word is taken until it leaves. Reset clears all valid bits and sets
// entry_lifetime to 1000 ms. entry_lifetime_we_i writes the register; the
// user must assert it only while idle, as the block itself does not enforce
// this.
// ----------------------------------------------------------------------------
module greedy_geo_neighbor_table #(
  parameter int unsigned TableEntries = ggnt_pkg::TableEntriesDef,
  parameter int unsigned CoordBits    = ggnt_pkg::CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        entry_lifetime_we_i,
  input  logic [15:0]                 entry_lifetime_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  mode_i,
  input  logic [31:0]                 node_addr_i,
  input  logic signed [CoordBits-1:0] pos_x_i,
  input  logic signed [CoordBits-1:0] pos_y_i,
  input  logic signed [CoordBits-1:0] self_x_i,
  input  logic signed [CoordBits-1:0] self_y_i,
  input  logic [31:0]                 now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [31:0]                 next_hop_o,
  output logic                        is_present_o,
  output logic [31:0]                 entry_time_o
);
  import ggnt_pkg::*;

  localparam int unsigned IdxW  = $clog2(TableEntries);
  localparam int unsigned CntW  = $clog2(TableEntries + 1);
  localparam int unsigned MemW  = 64 + 2 * CoordBits;
  localparam int unsigned DiffW = CoordBits + 1;
  localparam int unsigned SqW   = 2 * DiffW;
  localparam int unsigned DistW = SqW + 1;

  fsm_e state_q, state_d;
  logic [TableEntries-1:0] valid_q, valid_d;
  logic [15:0] life_q;
  logic [2:0]  mode_q;
  logic [31:0] addr_q, now_q;
  logic signed [CoordBits-1:0] px_q, py_q, sx_q, sy_q;

  logic [CntW-1:0] issue_q, issue_d;   // next entry to read
  logic            rvld_q;             // RAM data valid this cycle
  logic [IdxW-1:0] ridx_q;             // entry of RAM data

  logic            hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic [31:0]     hit_time_q, hit_time_d;
  logic            free_q, free_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;

  logic            best_q, best_d;
  logic [DistW-1:0] bestd_q, bestd_d;
  logic [31:0]     besta_q, besta_d;

  // distance stage
  logic [SqW-1:0]  sqx_q, sqy_q;
  logic [31:0]     da_q;
  logic            dvld_q;

  logic [1:0]  st_q;
  logic [31:0] hop_q, et_q;
  logic        pr_q;

  logic        mem_we;
  logic [IdxW-1:0] mem_wa, mem_ra;
  logic [MemW-1:0] mem_wd, mem_rd;

  ggnt_mem #(.Depth(TableEntries), .Width(MemW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .raddr_i (mem_ra),
    .rdata_o (mem_rd)
  );

  // RAM word: {addr, stamp, x, y}
  logic [31:0] r_addr, r_stamp;
  logic signed [CoordBits-1:0] r_x, r_y;
  assign r_addr  = mem_rd[MemW-1 -: 32];
  assign r_stamp = mem_rd[MemW-33 -: 32];
  assign r_x     = mem_rd[2*CoordBits-1 -: CoordBits];
  assign r_y     = mem_rd[CoordBits-1:0];

  logic r_live, r_expired;
  assign r_live    = rvld_q && valid_q[ridx_q];
  assign r_expired = ({1'b0, r_stamp} + {17'd0, life_q}) <= {1'b0, now_q};

  logic accept;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != FSM_IDLE) || out_valid_o;

  logic last_issued;
  assign last_issued = (issue_q == CntW'(TableEntries));

  // a live best-neighbor entry re-reads itself so DIST sees its data
  logic go_dist;
  assign go_dist = (state_q == FSM_SCAN) && mode_q == MODE_BEST && r_live && !r_expired;
  assign mem_ra  = go_dist ? ridx_q : issue_q[IdxW-1:0];

  // absolute differences for the streamed entry
  logic signed [DiffW-1:0] dx, dy;
  logic [DiffW-1:0] ax, ay;
  always_comb begin
    dx = DiffW'(r_x) - DiffW'(px_q);
    dy = DiffW'(r_y) - DiffW'(py_q);
    ax = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
    ay = dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);
  end

  // self distance, shares the squaring path in FINISH
  logic signed [DiffW-1:0] sdx, sdy;
  logic [DiffW-1:0] sax, say;
  always_comb begin
    sdx = DiffW'(sx_q) - DiffW'(px_q);
    sdy = DiffW'(sy_q) - DiffW'(py_q);
    sax = sdx[DiffW-1] ? DiffW'(-sdx) : DiffW'(sdx);
    say = sdy[DiffW-1] ? DiffW'(-sdy) : DiffW'(sdy);
  end

  logic [DistW-1:0] dsum;
  assign dsum = DistW'(sqx_q) + DistW'(sqy_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = (mode_i == MODE_CLEAR || mode_i > MODE_QUERY) ? FSM_OUT : FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (mode_q == MODE_BEST && r_live && !r_expired) state_d = FSM_DIST;
        else if (last_issued && !rvld_q)
          state_d = (mode_q == MODE_BEST) ? FSM_FINISH : FSM_WRITE;
      end
      FSM_DIST:   state_d = last_issued ? FSM_FINISH : FSM_SCAN;
      FSM_FINISH: state_d = dvld_q ? FSM_FINISH : FSM_WRITE;
      FSM_WRITE:  state_d = FSM_OUT;
      FSM_OUT:    state_d = FSM_IDLE;
      default:    state_d = FSM_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    issue_d    = issue_q;
    valid_d    = valid_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_time_d = hit_time_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    best_d     = best_q;
    bestd_d    = bestd_q;
    besta_d    = besta_q;
    mem_we     = 1'b0;
    mem_wa     = hit_q ? hit_idx_q : free_idx_q;
    mem_wd     = {addr_q, now_q, px_q, py_q};
    unique case (state_q)
      FSM_IDLE: begin
        issue_d = '0;
        hit_d   = 1'b0;
        free_d  = 1'b0;
        best_d  = 1'b0;
        if (accept && mode_i == MODE_CLEAR) valid_d = '0;
      end
      FSM_SCAN: begin
        if (!last_issued && !(mode_q == MODE_BEST && r_live && !r_expired))
          issue_d = issue_q + 1'b1;
        if (rvld_q) begin
          if (mode_q == MODE_BEST) begin
            if (r_live && r_expired) valid_d[ridx_q] = 1'b0;
          end else begin
            if (r_live && r_addr == addr_q && !hit_q) begin
              hit_d      = 1'b1;
              hit_idx_d  = ridx_q;
              hit_time_d = r_stamp;
            end
            if (!valid_q[ridx_q] && !free_d) begin
              free_d     = 1'b1;
              free_idx_d = ridx_q;
            end
          end
        end
      end
      FSM_DIST: begin
        if (!last_issued) issue_d = issue_q + 1'b1;
      end
      FSM_FINISH: ;
      FSM_WRITE: begin
        if (mode_q == MODE_ADD && (hit_q || free_q)) begin
          mem_we  = 1'b1;
          valid_d[mem_wa] = 1'b1;
        end
        if (mode_q == MODE_DEL && hit_q) valid_d[hit_idx_q] = 1'b0;
      end
      FSM_OUT: ;
      default: ;
    endcase
    // fold in the squares registered on the cycle before
    if (dvld_q) begin
      if (!best_q || dsum < bestd_q || (dsum == bestd_q && da_q < besta_q)) begin
        best_d  = 1'b1;
        bestd_d = dsum;
        besta_d = da_q;
      end
    end
  end

  // squaring stage: entry in DIST, self in FINISH of a best command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q <= 1'b0;
    end else begin
      dvld_q <= (state_q == FSM_DIST);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FSM_DIST) begin
      sqx_q <= ax * ax;
      sqy_q <= ay * ay;
      da_q  <= r_addr;
    end else if (state_q == FSM_FINISH && !dvld_q) begin
      sqx_q <= sax * sax;
      sqy_q <= say * say;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == FSM_IDLE && accept) begin
      st_q <= ST_OK; hop_q <= '0; pr_q <= 1'b0; et_q <= '0;
    end else if (state_q == FSM_WRITE) begin
      unique case (mode_q)
        MODE_ADD:   st_q <= (hit_q || free_q) ? ST_OK : ST_FULL;
        MODE_QUERY: begin
          pr_q <= hit_q;
          et_q <= hit_q ? hit_time_q : 32'd0;
        end
        MODE_BEST: begin
          if (!best_q) st_q <= ST_EMPTY;
          else if (dsum > bestd_q) hop_q <= besta_q;
          else st_q <= ST_NOBEST;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      valid_q     <= '0;
      life_q      <= LifetimeReset;
      issue_q     <= '0;
      rvld_q      <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      best_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      issue_q <= issue_d;
      hit_q   <= hit_d;
      free_q  <= free_d;
      best_q  <= best_d;
      if (entry_lifetime_we_i) life_q <= entry_lifetime_i;
      rvld_q  <= (state_d == FSM_SCAN || state_d == FSM_DIST) && issue_d != issue_q
                 || (state_q == FSM_IDLE && state_d == FSM_SCAN);
      if (state_q == FSM_OUT) out_valid_o <= 1'b1;
      else if (!out_stall_i)  out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= mem_ra;
    if (accept) begin
      mode_q <= mode_i;
      addr_q <= node_addr_i;
      now_q  <= now_ms_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      sx_q   <= self_x_i;
      sy_q   <= self_y_i;
    end
    hit_idx_q  <= hit_idx_d;
    hit_time_q <= hit_time_d;
    free_idx_q <= free_idx_d;
    bestd_q    <= bestd_d;
    besta_q    <= besta_d;
  end

  assign status_o     = st_q;
  assign next_hop_o   = hop_q;
  assign is_present_o = pr_q;
  assign entry_time_o = et_q;
endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives command words into greedy_geo_neighbor_table with random gaps and
// output stalls, predicts every result word from a behavioral table model
// and compares field by field. Lifetime is changed between phases.
// ----------------------------------------------------------------------------
import ggnt_pkg::*;

typedef struct {
  logic [1:0]  status;
  logic [31:0] next_hop;
  logic        is_present;
  logic [31:0] entry_time;
} nbr_result_t;

class nbr_table_sb;
  localparam int Depth = 16;
  bit          vld [Depth];
  logic [31:0] addr[Depth];
  logic signed [19:0] ex[Depth];
  logic signed [19:0] ey[Depth];
  logic [31:0] stamp[Depth];
  logic [15:0] lifetime;
  nbr_result_t pending[$];
  int mismatches;

  function new();
    lifetime = LifetimeReset;
    foreach (vld[k]) vld[k] = 0;
    mismatches = 0;
  endfunction

  function int find_addr(logic [31:0] a);
    for (int k = 0; k < Depth; k++)
      if (vld[k] && addr[k] == a) return k;
    return -1;
  endfunction

  function longint sq_dist(logic signed [19:0] ax, logic signed [19:0] ay,
                           logic signed [19:0] bx, logic signed [19:0] by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return dx * dx + dy * dy;
  endfunction

  // Predict the result of one accepted command and update the table copy.
  function void note_command(logic [2:0] mode, logic [31:0] a,
                             logic signed [19:0] px, logic signed [19:0] py,
                             logic signed [19:0] sx, logic signed [19:0] sy,
                             logic [31:0] now);
    nbr_result_t r;
    int k, best;
    longint d, bestd;
    r = '{2'd0, 32'd0, 1'b0, 32'd0};
    case (mode)
      MODE_ADD: begin
        k = find_addr(a);
        if (k < 0)
          for (k = 0; k < Depth; k++) if (!vld[k]) break;
        if (k >= Depth) r.status = ST_FULL;
        else begin
          vld[k] = 1; addr[k] = a; ex[k] = px; ey[k] = py; stamp[k] = now;
        end
      end
      MODE_DEL: begin
        k = find_addr(a);
        if (k >= 0) vld[k] = 0;
      end
      MODE_CLEAR: foreach (vld[j]) vld[j] = 0;
      MODE_BEST: begin
        best = -1;
        bestd = 0;
        // expiry uses an unwrapped 33-bit sum
        for (k = 0; k < Depth; k++)
          if (vld[k] && {1'b0, stamp[k]} + lifetime <= {1'b0, now}) vld[k] = 0;
        for (k = 0; k < Depth; k++) begin
          if (!vld[k]) continue;
          d = sq_dist(ex[k], ey[k], px, py);
          if (best < 0 || d < bestd || (d == bestd && addr[k] < addr[best])) begin
            best = k;
            bestd = d;
          end
        end
        if (best < 0) r.status = ST_EMPTY;
        else if (sq_dist(sx, sy, px, py) > bestd) r.next_hop = addr[best];
        else r.status = ST_NOBEST;
      end
      MODE_QUERY: begin
        k = find_addr(a);
        if (k >= 0) begin
          r.is_present = 1;
          r.entry_time = stamp[k];
        end
      end
      default: ;
    endcase
    pending.push_back(r);
  endfunction

  function void check_result(nbr_result_t got);
    nbr_result_t exp_r;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word %p", got);
      return;
    end
    exp_r = pending.pop_front();
    if (got.status !== exp_r.status || got.next_hop !== exp_r.next_hop ||
        got.is_present !== exp_r.is_present || got.entry_time !== exp_r.entry_time) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected %p got %p", exp_r, got);
    end
  endfunction
endclass

module testbench;
  logic clk_i = 0;
  logic rst_ni = 0;
  logic lt_we = 0;
  logic [15:0] lt_data = 0;
  logic in_valid = 0, in_stall;
  logic [2:0] mode = 0;
  logic [31:0] node_addr = 0, now_ms = 0;
  logic signed [19:0] pos_x = 0, pos_y = 0, self_x = 0, self_y = 0;
  logic out_valid, out_stall = 0;
  logic [1:0] status;
  logic [31:0] next_hop, entry_time;
  logic is_present;

  nbr_table_sb tbl_model = new();
  logic [31:0] clock_ms = 0;  // running time base for stamps

  // Small address pool so refresh, delete and query hit stored entries.
  logic [31:0] addr_pool[24];

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  greedy_geo_neighbor_table uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .entry_lifetime_we_i(lt_we), .entry_lifetime_i(lt_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mode_i(mode), .node_addr_i(node_addr),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .self_x_i(self_x), .self_y_i(self_y),
    .now_ms_i(now_ms),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .next_hop_o(next_hop),
    .is_present_o(is_present), .entry_time_o(entry_time)
  );

  function int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random stalls, check each accepted result word.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall)
      tbl_model.check_result('{status, next_hop, is_present, entry_time});
  end

  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        n = gap_len();
        if (n > 0) begin
          out_stall <= 1;
          repeat (n) @(negedge clk_i);
        end
      end
      out_stall <= 0;
    end
  end

  // Present one word and hold it until accepted; returns at the accepting edge.
  task send_word(logic [2:0] m, logic [31:0] a, logic signed [19:0] px,
                 logic signed [19:0] py, logic signed [19:0] sx,
                 logic signed [19:0] sy, logic [31:0] t);
    int n;
    n = gap_len();
    @(negedge clk_i);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk_i);
    end
    mode <= m; node_addr <= a; pos_x <= px; pos_y <= py;
    self_x <= sx; self_y <= sy; now_ms <= t;
    in_valid <= 1;
    do @(posedge clk_i); while (in_stall);
    tbl_model.note_command(m, a, px, py, sx, sy, t);
  endtask

  task wait_drained();
    @(negedge clk_i);
    in_valid <= 0;
    while (tbl_model.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task set_lifetime(logic [15:0] v);
    wait_drained();
    @(negedge clk_i);
    lt_we <= 1;
    lt_data <= v;
    @(negedge clk_i);
    lt_we <= 0;
    tbl_model.lifetime = v;
  endtask

  function logic signed [19:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return 20'($urandom_range(0, 200)) - 20'd100;
      1: return $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
      default: return 20'($urandom);
    endcase
  endfunction

  task random_phase(int count);
    logic [2:0] m;
    logic [31:0] a;
    int p;
    logic signed [19:0] qx, qy;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 99);
      if (p < 40) m = MODE_ADD;
      else if (p < 52) m = MODE_DEL;
      else if (p < 55) m = MODE_CLEAR;
      else if (p < 80) m = MODE_BEST;
      else if (p < 96) m = MODE_QUERY;
      else m = 3'($urandom_range(5, 7));
      a = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, 23)];
      clock_ms += $urandom_range(0, 400);
      qx = rnd_coord();
      qy = rnd_coord();
      // self near destination sometimes so the no-closer case shows up
      if ($urandom_range(0, 3) == 0)
        send_word(m, a, qx, qy, qx + 20'sd1, qy, clock_ms);
      else
        send_word(m, a, qx, qy, rnd_coord(), rnd_coord(), clock_ms);
    end
  endtask

  initial begin
    addr_pool[0] = 32'd0;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < 24; k++) addr_pool[k] = $urandom;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // directed: empty table, adds with extreme fields, full table, ties
    send_word(MODE_BEST, 0, 0, 0, 0, 0, 32'd10);
    send_word(MODE_QUERY, 32'd5, 0, 0, 0, 0, 32'd10);
    send_word(MODE_ADD, 32'd0, 20'sh80000, 20'sh80000, 0, 0, 32'd20);
    send_word(MODE_ADD, 32'hFFFF_FFFF, 20'sh7FFFF, 20'sh7FFFF, 0, 0, 32'd30);
    send_word(MODE_BEST, 0, 20'sh7FFFF, 20'sh7FFFF, 20'sh80000, 20'sh80000, 32'd40);
    send_word(MODE_BEST, 0, 20'sh80000, 20'sh80000, 20'sh80000, 20'sh80000, 32'd40);
    for (int k = 0; k < 15; k++)
      send_word(MODE_ADD, 32'h100 + k, 20'sd5, 20'sd5, 0, 0, 32'd50);
    send_word(MODE_BEST, 0, 20'sd5, 20'sd5, 20'sd100, 0, 32'd60);
    send_word(MODE_ADD, 32'h200, 0, 0, 0, 0, 32'd60);
    send_word(MODE_ADD, 32'h100, 20'sd9, 20'sd9, 0, 0, 32'd70);
    send_word(MODE_QUERY, 32'h100, 0, 0, 0, 0, 32'd70);
    send_word(MODE_DEL, 32'h100, 0, 0, 0, 0, 32'd70);
    send_word(MODE_DEL, 32'h999, 0, 0, 0, 0, 32'd70);
    send_word(3'd7, 32'hFFFF_FFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF,
              32'hFFFF_FFFF);
    send_word(MODE_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0, 32'd1000);
    send_word(MODE_BEST, 0, 0, 0, 20'sd1, 0, 32'd1050);
    send_word(MODE_QUERY, 32'd0, 0, 0, 0, 0, 32'd1050);
    send_word(MODE_CLEAR, 0, 0, 0, 0, 0, 32'd1100);

    clock_ms = 32'd2000;
    random_phase(120);
    set_lifetime(16'd0);
    random_phase(40);
    set_lifetime(16'hFFFF);
    random_phase(120);
    set_lifetime(16'd300);
    random_phase(100);
    // near the top of time: no wrap in the expiry sum
    set_lifetime(16'hFFFF);
    clock_ms = 32'hFFFF_0000;
    random_phase(20);

    wait_drained();
    if (tbl_model.mismatches == 0 && tbl_model.pending.size() == 0)
      $display("greedy_geo_neighbor_table test passed");
    else
      $display("greedy_geo_neighbor_table test failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("greedy_geo_neighbor_table test failed");
    $finish;
  end
endmodule
